// File: hw/rtl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int StW   = 2;

  // Result queue depth; must hold two results of one byte plus slack.
  localparam int ResDepth = 4;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_SHORT = 2'd1;
  localparam logic [StW-1:0] ST_WIDE  = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             item_kind;
    logic [StW-1:0]   status_code;
    logic [LenW-1:0]  payload_length;
    logic             run_last;
  } res_t;

  function automatic res_t mk_data(logic [ByteW-1:0] b);
    res_t r;
    r                = '0;
    r.out_byte       = b;
    r.item_kind      = KIND_DATA;
    return r;
  endfunction

  function automatic res_t mk_status(logic [StW-1:0] st, logic [LenW-1:0] len);
    res_t r;
    r                = '0;
    r.item_kind      = KIND_STATUS;
    r.status_code    = st;
    r.payload_length = len;
    r.run_last       = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wsd_if.sv
`default_nettype none

interface wsd_in_if;
  logic                     valid;
  logic                     ready;
  logic [wsd_pkg::ByteW-1:0] data_byte;
  logic                     end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wsd_out_if;
  logic                     valid;
  logic                     ready;
  logic [wsd_pkg::ByteW-1:0] out_byte;
  logic                     item_kind;
  logic [wsd_pkg::StW-1:0]  status_code;
  logic [wsd_pkg::LenW-1:0] payload_length;
  logic                     run_last;

  modport source (output valid, output out_byte, output item_kind, output status_code,
                  output payload_length, output run_last, input ready);
  modport sink   (input valid, input out_byte, input item_kind, input status_code,
                  input payload_length, input run_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer. Takes one received frame buffer a byte per request
// (end_of_buffer on its last byte), decodes the 7-bit or 16-bit payload length,
// captures the masking key and emits each payload byte unmasked, then one status
// item (ok with the length, too short, or 64-bit length unsupported) with
// run_last set. Header and trailing bytes give no data item. One byte is
// accepted per cycle; each byte is decoded in the cycle it is accepted and its
// results land in a four-entry result queue. The last payload byte gives two
// results; the queue drains one per cycle while out_bus.ready is high, and
// in_bus.ready drops only while fewer than two queue slots are free.
`default_nettype none

module websocket_frame_deframer_core (
  input  wire        clk,
  input  wire        rst_n,
  wsd_in_if.sink     in_bus,
  wsd_out_if.source  out_bus
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_KEY    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_DRAIN  = 3'd6;

  localparam int PtrW = $clog2(wsd_pkg::ResDepth);
  localparam int CntW = PtrW + 1;

  logic [2:0]                  phase_r, phase_nxt;
  logic [wsd_pkg::LenW-1:0]    length_r, length_nxt;
  logic [wsd_pkg::LenW-1:0]    bcount_r, bcount_nxt;
  logic                        mask_en_r, mask_en_nxt;
  logic [wsd_pkg::ByteW-1:0]   key_r [4];
  logic [1:0]                  kidx_r, kidx_nxt;

  wsd_pkg::res_t               q_r [wsd_pkg::ResDepth];
  logic [PtrW-1:0]             wptr_r, rptr_r;
  logic [CntW-1:0]             cnt_r, cnt_nxt;

  logic                        acc, pop;
  logic [wsd_pkg::ByteW-1:0]   b;
  logic [wsd_pkg::LenW-1:0]    bcount_inc;
  logic                        data_push, stat_push, key_wr;
  wsd_pkg::res_t               data_res, stat_res, res0;
  logic [1:0]                  n_push;

  assign acc = in_bus.valid && in_bus.ready;
  assign pop = out_bus.valid && out_bus.ready;
  assign b   = in_bus.data_byte;
  assign bcount_inc = bcount_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    length_nxt  = length_r;
    bcount_nxt  = bcount_r;
    mask_en_nxt = mask_en_r;
    kidx_nxt    = kidx_r;
    key_wr      = 1'b0;
    data_push   = 1'b0;
    stat_push   = 1'b0;
    data_res    = wsd_pkg::mk_data(b ^ (mask_en_r ? key_r[bcount_r[1:0]] : 8'h00));
    stat_res    = wsd_pkg::mk_status(wsd_pkg::ST_OK, 16'd0);
    if (acc) begin
      case (phase_r)
        PH_HDR0: begin
          bcount_nxt  = '0;
          kidx_nxt    = '0;
          length_nxt  = '0;
          mask_en_nxt = 1'b0;
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          mask_en_nxt = b[7];
          if (b[6:0] == wsd_pkg::LEN_EXT64) begin
            stat_push = 1'b1;
            stat_res  = wsd_pkg::mk_status(wsd_pkg::ST_WIDE, 16'd0);
            phase_nxt = PH_DRAIN;
          end else if (b[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_nxt = PH_EXT_HI;
          end else begin
            length_nxt = {9'd0, b[6:0]};
            if (b[7]) begin
              phase_nxt = PH_KEY;
            end else if (b[6:0] == 7'd0) begin
              stat_push = 1'b1;
              phase_nxt = PH_DRAIN;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_EXT_HI: begin
          length_nxt = {b, 8'h00};
          phase_nxt  = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          length_nxt = {length_r[15:8], b};
          if (mask_en_r) begin
            phase_nxt = PH_KEY;
          end else if ({length_r[15:8], b} == 16'd0) begin
            stat_push = 1'b1;
            phase_nxt = PH_DRAIN;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_KEY: begin
          key_wr = 1'b1;
          if (kidx_r == 2'd3) begin
            kidx_nxt = '0;
            if (length_r == 16'd0) begin
              stat_push = 1'b1;
              phase_nxt = PH_DRAIN;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            kidx_nxt = kidx_r + 2'd1;
          end
        end
        PH_DATA: begin
          data_push  = 1'b1;
          bcount_nxt = bcount_inc;
          if (bcount_inc == length_r) begin
            stat_push = 1'b1;
            stat_res  = wsd_pkg::mk_status(wsd_pkg::ST_OK, length_r);
            phase_nxt = PH_DRAIN;
          end
        end
        default: begin
          phase_nxt = PH_DRAIN;
        end
      endcase
      if (in_bus.end_of_buffer) begin
        if (phase_nxt != PH_DRAIN) begin
          stat_push = 1'b1;
          stat_res  = wsd_pkg::mk_status(wsd_pkg::ST_SHORT, 16'd0);
        end
        phase_nxt = PH_HDR0;
      end
    end
  end

  assign res0   = data_push ? data_res : stat_res;
  assign n_push = {1'b0, data_push} + {1'b0, stat_push};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      length_r  <= '0;
      bcount_r  <= '0;
      mask_en_r <= 1'b0;
      kidx_r    <= '0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      length_r  <= length_nxt;
      bcount_r  <= bcount_nxt;
      mask_en_r <= mask_en_nxt;
      kidx_r    <= kidx_nxt;
      if (key_wr) begin
        key_r[kidx_r] <= b;
      end
    end
  end

  // Result queue
  assign cnt_nxt = cnt_r + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + PtrW'(n_push);
      rptr_r <= rptr_r + PtrW'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wptr_r + PtrW'(1)] <= stat_res;
    end
  end

  assign in_bus.ready           = cnt_r <= CntW'(wsd_pkg::ResDepth - 2);
  assign out_bus.valid          = cnt_r != '0;
  assign out_bus.out_byte       = q_r[rptr_r].out_byte;
  assign out_bus.item_kind      = q_r[rptr_r].item_kind;
  assign out_bus.status_code    = q_r[rptr_r].status_code;
  assign out_bus.payload_length = q_r[rptr_r].payload_length;
  assign out_bus.run_last       = q_r[rptr_r].run_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(wsd_pkg::ResDepth))
    else $error("result queue overflow");

  a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_bus.end_of_buffer |=> phase_r == PH_HDR0)
    else $error("end of buffer did not rearm header");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bcount_r < length_r)
    else $error("payload count passed length");

  a_hdr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_HDR0 && !in_bus.end_of_buffer |-> n_push == 2'd0)
    else $error("result on first header byte");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] P_HDR0   = 3'd0;
  localparam logic [2:0] P_LEN    = 3'd1;
  localparam logic [2:0] P_EXT_HI = 3'd2;
  localparam logic [2:0] P_EXT_LO = 3'd3;
  localparam logic [2:0] P_KEY    = 3'd4;
  localparam logic [2:0] P_DATA   = 3'd5;
  localparam logic [2:0] P_DRAIN  = 3'd6;

  typedef struct {
    logic [7:0] b;
    logic       eob;
    bit         hold;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_deframer_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always #5 clk = ~clk;

  req_t          pending[$];
  wsd_pkg::res_t res_due[$];
  int   fails = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  bit   calm = 1'b0;

  // deframer state
  logic [2:0]   fph = P_HDR0;
  logic [15:0]  flen = '0;
  logic [15:0]  fcount = '0;
  logic         fmask = 1'b0;
  logic [7:0]   fkey[4] = '{default: 8'h00};
  logic [1:0]   fkey_pos = '0;

  task automatic emit_status(input logic [wsd_pkg::StW-1:0] st,
                             input logic [wsd_pkg::LenW-1:0] len);
    wsd_pkg::res_t r;
    r = '0;
    r.item_kind = wsd_pkg::KIND_STATUS;
    r.status_code = st;
    r.payload_length = len;
    r.run_last = 1'b1;
    res_due.push_back(r);
  endtask

  task automatic start_payload();
    if (flen == 16'd0) begin
      emit_status(wsd_pkg::ST_OK, 16'd0);
      fph = P_DRAIN;
    end else begin
      fph = P_DATA;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    logic [6:0] code;
    wsd_pkg::res_t r;
    code = b[6:0];
    case (fph)
      P_HDR0: begin
        fcount = '0;
        fkey_pos = '0;
        flen = '0;
        fmask = 1'b0;
        fph = P_LEN;
      end
      P_LEN: begin
        fmask = b[7];
        if (code == wsd_pkg::LEN_EXT64) begin
          emit_status(wsd_pkg::ST_WIDE, 16'd0);
          fph = P_DRAIN;
        end else if (code == wsd_pkg::LEN_EXT16) begin
          fph = P_EXT_HI;
        end else begin
          flen = {9'd0, code};
          if (fmask) fph = P_KEY;
          else start_payload();
        end
      end
      P_EXT_HI: begin
        flen = {b, 8'h00};
        fph = P_EXT_LO;
      end
      P_EXT_LO: begin
        flen[7:0] = b;
        if (fmask) fph = P_KEY;
        else start_payload();
      end
      P_KEY: begin
        fkey[fkey_pos] = b;
        if (fkey_pos == 2'd3) begin
          fkey_pos = '0;
          start_payload();
        end else begin
          fkey_pos = fkey_pos + 2'd1;
        end
      end
      P_DATA: begin
        r = '0;
        r.item_kind = wsd_pkg::KIND_DATA;
        r.out_byte = fmask ? (b ^ fkey[fcount[1:0]]) : b;
        res_due.push_back(r);
        fcount = fcount + 16'd1;
        if (fcount == flen) begin
          emit_status(wsd_pkg::ST_OK, flen);
          fph = P_DRAIN;
        end
      end
      default: fph = P_DRAIN;
    endcase
    if (eob) begin
      if (fph != P_DRAIN) emit_status(wsd_pkg::ST_SHORT, 16'd0);
      fph = P_HDR0;
    end
  endtask

  task automatic add_req(input logic [7:0] b, input logic eob, input bit hold);
    req_t q;
    q.b = b;
    q.eob = eob;
    q.hold = hold;
    pending.push_back(q);
  endtask

  // n bytes, first byte in the most significant position; flag on the last
  task automatic add_run(input int n, input logic [63:0] v);
    for (int i = 0; i < n; i++) add_req(v[8*(n-1-i) +: 8], i == n - 1, 1'b0);
  endtask

  task automatic add_frame(input bit hold);
    logic [7:0]  fb[$];
    int          sel;
    int          plen;
    int          cut;
    bit          m;
    logic [15:0] xlen;
    m = 1'($urandom_range(0, 1));
    fb.push_back(8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      repeat ($urandom_range(0, 5)) fb.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 13) begin
      fb.push_back({m, wsd_pkg::LEN_EXT64});
      repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (sel < 30) begin
        if ($urandom_range(0, 3) == 0) xlen = 16'($urandom_range(0, 65535));
        else xlen = 16'($urandom_range(0, 40));
        fb.push_back({m, wsd_pkg::LEN_EXT16});
        fb.push_back(xlen[15:8]);
        fb.push_back(xlen[7:0]);
      end else begin
        if ($urandom_range(0, 3) == 0) xlen = 16'($urandom_range(0, 125));
        else xlen = 16'($urandom_range(0, 24));
        fb.push_back({m, xlen[6:0]});
      end
      if (m) repeat (4) fb.push_back(8'($urandom_range(0, 255)));
      plen = (xlen > 16'd130) ? 130 : int'(xlen);
      repeat (plen) fb.push_back(8'($urandom_range(0, 255)));
      if (xlen <= 16'd130 && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
      if (xlen > 16'd130 || $urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, fb.size() - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end
    end
    for (int i = 0; i < fb.size(); i++) add_req(fb[i], i == fb.size() - 1, hold && i == 0);
  endtask

  // request driver
  always @(posedge clk) begin : drv
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.end_of_buffer <= 1'b0;
      in_gap <= 0;
      calm <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.data_byte, in_ch.end_of_buffer);
      calm <= (pending.size() < 150);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending.size() == 0 || (pending[0].hold && res_due.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 14);
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= nxt.b;
          in_ch.end_of_buffer <= nxt.eob;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    wsd_pkg::res_t got;
    wsd_pkg::res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.item_kind = out_ch.item_kind;
        got.status_code = out_ch.status_code;
        got.payload_length = out_ch.payload_length;
        got.run_last = out_ch.run_last;
        if (res_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result byte=%h kind=%b st=%0d len=%0d last=%b",
                     $realtime, got.out_byte, got.item_kind, got.status_code,
                     got.payload_length, got.run_last);
        end else begin
          want = res_due.pop_front();
          if (got.out_byte !== want.out_byte || got.item_kind !== want.item_kind ||
              got.status_code !== want.status_code ||
              got.payload_length !== want.payload_length ||
              got.run_last !== want.run_last) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch exp byte=%h kind=%b st=%0d len=%0d last=%b",
                        " got byte=%h kind=%b st=%0d len=%0d last=%b"},
                       $realtime, want.out_byte, want.item_kind, want.status_code,
                       want.payload_length, want.run_last, got.out_byte, got.item_kind,
                       got.status_code, got.payload_length, got.run_last);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready = 1'b0;

    add_run(2, 64'h00_00);
    add_run(7, 64'h82_81_11_22_33_44_A5);
    add_run(1, 64'h81);
    add_run(5, 64'h01_7E_FF_FF_12);
    add_run(3, 64'h02_FF_55);
    add_run(4, 64'h7F_01_3C_C3);
    add_run(6, 64'h00_80_DE_AD_BE_EF);
    add_frame(1'b1);
    while (pending.size() < 1800) add_frame(1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_ch.valid || res_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && res_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: websocket_frame_deframer_core.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_if.sv
hw/rtl/websocket_frame_deframer_core.sv
bench/testbench.sv
